// ===== hdl/fof_pkg.sv =====
// ----------------------------------------------------------------------------
// fof_pkg
// Shared widths, command codes and memory request types for the
// frequency-of-frequency table.
// ----------------------------------------------------------------------------
package fof_pkg;

  localparam int VALUE_BITS = 10;
  localparam int COUNT_BITS = 10;
  localparam int OPER_BITS  = 10;
  localparam int CMD_BITS   = 2;
  localparam int BKT_BITS   = VALUE_BITS + 1;
  localparam int CLR_BITS   = (VALUE_BITS > COUNT_BITS) ? VALUE_BITS : COUNT_BITS;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
  localparam logic [BKT_BITS-1:0]   BKT_ONE    = BKT_BITS'(1);
  localparam logic [CLR_BITS-1:0]   CLR_LAST   = '1;

  localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic                  we;
    logic [VALUE_BITS-1:0] waddr;
    logic [COUNT_BITS-1:0] wdata;
    logic [VALUE_BITS-1:0] raddr;
  } cnt_req_t;

  typedef struct packed {
    logic                  we;
    logic [COUNT_BITS-1:0] waddr;
    logic [BKT_BITS-1:0]   wdata;
    logic [COUNT_BITS-1:0] raddr;
  } bkt_req_t;

endpackage

// ===== hdl/fof_ram.sv =====
// ----------------------------------------------------------------------------
// fof_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module fof_ram #(
  parameter int WIDTH = 8,
  parameter int ABITS = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [ABITS-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**ABITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/fof_ctrl.sv =====
// ----------------------------------------------------------------------------
// fof_ctrl
// Command sequencer: clears both memories after reset, then runs the
// read-modify-write steps of each command and holds the query result.
// ----------------------------------------------------------------------------
module fof_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fof_pkg::CMD_BITS-1:0]  in_command,
  input  logic [fof_pkg::OPER_BITS-1:0] in_operand,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_present,
  output fof_pkg::cnt_req_t             cnt_req,
  input  logic [fof_pkg::COUNT_BITS-1:0] cnt_rdata,
  output fof_pkg::bkt_req_t             bkt_req,
  input  logic [fof_pkg::BKT_BITS-1:0]   bkt_rdata
);

  import fof_pkg::*;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_CNT,
    S_DEC,
    S_INC,
    S_QRY
  } state_t;

  state_t                state_r, state_nxt;
  logic [CMD_BITS-1:0]   cmd_r, cmd_nxt;
  logic [OPER_BITS-1:0]  op_r, op_nxt;
  logic [COUNT_BITS-1:0] c1_r, c1_nxt;
  logic [COUNT_BITS-1:0] c2_r, c2_nxt;
  logic                  inc_r, inc_nxt;
  logic [CLR_BITS-1:0]   clr_r, clr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_present_r, out_present_nxt;

  logic                  dec_c;
  logic                  inc_c;
  logic [COUNT_BITS-1:0] c2_c;
  logic                  hit_c;

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    op_nxt          = op_r;
    c1_nxt          = c1_r;
    c2_nxt          = c2_r;
    inc_nxt         = inc_r;
    clr_nxt         = clr_r;
    out_valid_nxt   = out_valid_r;
    out_present_nxt = out_present_r;
    in_ready        = 1'b0;
    cnt_req         = '0;
    bkt_req         = '0;
    dec_c           = 1'b0;
    inc_c           = 1'b0;
    c2_c            = cnt_rdata;
    hit_c           = (op_r != '0) && ((32'(op_r) >> COUNT_BITS) == 32'd0) &&
                      (bkt_rdata != '0);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        cnt_req.we    = 1'b1;
        cnt_req.waddr = VALUE_BITS'(clr_r);
        bkt_req.we    = 1'b1;
        bkt_req.waddr = COUNT_BITS'(clr_r);
        clr_nxt       = clr_r + CLR_BITS'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready      = 1'b1;
        cnt_req.raddr = VALUE_BITS'(in_operand);
        bkt_req.raddr = COUNT_BITS'(in_operand);
        if (in_valid) begin
          cmd_nxt = in_command;
          op_nxt  = in_operand;
          unique case (in_command)
            CMD_INSERT, CMD_REMOVE: state_nxt = S_CNT;
            CMD_QUERY:              state_nxt = S_QRY;
            default:                state_nxt = S_IDLE;
          endcase
        end
      end
      S_CNT: begin
        cnt_req.waddr = VALUE_BITS'(op_r);
        if (cmd_r == CMD_INSERT) begin
          if (cnt_rdata != COUNT_MAX) begin
            cnt_req.we = 1'b1;
            c2_c       = cnt_rdata + COUNT_ONE;
            dec_c      = (cnt_rdata != '0);
            inc_c      = 1'b1;
          end
        end else begin
          if (cnt_rdata != '0) begin
            cnt_req.we = 1'b1;
            c2_c       = cnt_rdata - COUNT_ONE;
            dec_c      = 1'b1;
            inc_c      = (cnt_rdata != COUNT_ONE);
          end
        end
        cnt_req.wdata = c2_c;
        bkt_req.raddr = dec_c ? cnt_rdata : c2_c;
        c1_nxt        = cnt_rdata;
        c2_nxt        = c2_c;
        inc_nxt       = inc_c;
        if (dec_c) begin
          state_nxt = S_DEC;
        end else if (inc_c) begin
          state_nxt = S_INC;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DEC: begin
        bkt_req.we    = 1'b1;
        bkt_req.waddr = c1_r;
        bkt_req.wdata = bkt_rdata - BKT_ONE;
        bkt_req.raddr = c2_r;
        state_nxt     = inc_r ? S_INC : S_IDLE;
      end
      S_INC: begin
        bkt_req.we    = 1'b1;
        bkt_req.waddr = c2_r;
        bkt_req.wdata = bkt_rdata + BKT_ONE;
        state_nxt     = S_IDLE;
      end
      S_QRY: begin
        bkt_req.raddr = COUNT_BITS'(op_r);
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_present_nxt = hit_c;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r         <= cmd_nxt;
    op_r          <= op_nxt;
    c1_r          <= c1_nxt;
    c2_r          <= c2_nxt;
    inc_r         <= inc_nxt;
    out_present_r <= out_present_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_present = out_present_r;

endmodule

// ===== hdl/frequency_of_frequency_table.sv =====
// ----------------------------------------------------------------------------
// frequency_of_frequency_table
// Histogram of values together with a count of how many values share each
// frequency, answering whether a given frequency is currently held.
// ----------------------------------------------------------------------------
// After reset the block clears both memories, one entry per cycle, with
// in_ready low. It then takes one command at a time. An insert or remove
// passes through the states S_CNT, S_DEC and S_INC (S_DEC is skipped when
// the count moves up from zero, S_INC when it moves down to zero, and both
// when the count saturates or the value is absent), because the value count
// is read first and the two frequency buckets are then updated through the
// single write port of the bucket memory. A query passes through S_QRY, and
// its result sits in an output register so the next command is taken while
// it waits for out_ready. The unused command code is accepted and dropped.
module frequency_of_frequency_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fof_pkg::CMD_BITS-1:0]  in_command,
  input  logic [fof_pkg::OPER_BITS-1:0] in_operand,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_present
);

  import fof_pkg::*;

  cnt_req_t              cnt_req;
  bkt_req_t              bkt_req;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic [BKT_BITS-1:0]   bkt_rdata;

  fof_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_operand  (in_operand),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_present (out_present),
    .cnt_req     (cnt_req),
    .cnt_rdata   (cnt_rdata),
    .bkt_req     (bkt_req),
    .bkt_rdata   (bkt_rdata)
  );

  fof_ram #(
    .WIDTH (COUNT_BITS),
    .ABITS (VALUE_BITS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_req.we),
    .waddr (cnt_req.waddr),
    .wdata (cnt_req.wdata),
    .raddr (cnt_req.raddr),
    .rdata (cnt_rdata)
  );

  fof_ram #(
    .WIDTH (BKT_BITS),
    .ABITS (COUNT_BITS)
  ) u_bkt_ram (
    .clk   (clk),
    .we    (bkt_req.we),
    .waddr (bkt_req.waddr),
    .wdata (bkt_req.wdata),
    .raddr (bkt_req.raddr),
    .rdata (bkt_rdata)
  );

endmodule

// ===== hdl/fof_checker.sv =====
// ----------------------------------------------------------------------------
// fof_checker
// Port-level checks for the frequency-of-frequency table, bound to the top.
// ----------------------------------------------------------------------------
module fof_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [fof_pkg::CMD_BITS-1:0]  in_command,
  input logic [fof_pkg::OPER_BITS-1:0] in_operand,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_present
);

  import fof_pkg::*;

  // The clearing pass keeps the block closed and the result empty.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block open or result pending right after reset");

  // A waiting transfer keeps its command and operand.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_command) && $stable(in_operand))
    else $error("waiting command dropped or changed");

  // Accepting an update command always closes the block to new commands.
  a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_INSERT || in_command == CMD_REMOVE)
    |=> !in_ready)
    else $error("block ready right after an update transfer");

  // A new result only appears at the end of a query, while the block is busy.
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_present))
    else $error("stalled result changed or dropped");

endmodule

bind frequency_of_frequency_table fof_checker u_fof_checker (.*);
